[hw/rtl/queue_based_shortest_path_core_defines.svh]
// Assertion macros shared by the shortest-path core.
`ifndef QUEUE_BASED_SHORTEST_PATH_CORE_DEFINES_SVH
`define QUEUE_BASED_SHORTEST_PATH_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QBSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qbsp same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define QBSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qbsp next-cycle check failed");

`endif

[hw/rtl/qbsp_pkg.sv]
// Shared constants, types and command/status structs of the shortest-path core.
`timescale 1ns / 1ps
package qbsp_pkg;

    localparam int NODES    = 16;
    localparam int NODE_W   = $clog2(NODES);
    localparam int ADDR_W   = 2 * NODE_W;
    localparam int MEM_DEPTH = NODES * NODES;
    localparam int CNT_W    = NODE_W + 1;
    localparam int FIELD_W  = 4;
    localparam int WEIGHT_W = 14;
    localparam int DIST_W   = 18;

    localparam logic [NODE_W-1:0]   LAST_NODE      = NODE_W'(NODES - 1);
    localparam logic [WEIGHT_W-1:0] NO_EDGE        = 14'd9999;
    localparam logic [DIST_W-1:0]   UNREACHED_DIST = 18'd9999;
    localparam logic [DIST_W-1:0]   DIST_MAX       = 18'h3FFFF;

    typedef enum logic
    {
        KIND_LOAD = 1'b0,
        KIND_RUN  = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_START,
        ST_POP,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    typedef struct packed
    {
        logic              load;
        logic              run;
        logic              start;
        logic              pop;
        logic              issue;
        logic              emit;
        logic [NODE_W-1:0] idx;
    } cmd_t;

    typedef struct packed
    {
        logic queue_empty;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/qbsp_if.sv]
// Valid/ready channel interfaces for input items and result words.
`timescale 1ns / 1ps
interface qbsp_item_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [qbsp_pkg::FIELD_W-1:0]  row_node;
    logic [qbsp_pkg::FIELD_W-1:0]  col_node;
    logic [qbsp_pkg::WEIGHT_W-1:0] edge_weight;
    logic [qbsp_pkg::FIELD_W-1:0]  source_node;

    modport source
    (
        output valid, kind, row_node, col_node, edge_weight, source_node,
        input  ready
    );

    modport sink
    (
        input  valid, kind, row_node, col_node, edge_weight, source_node,
        output ready
    );
endinterface

interface qbsp_result_if;
    logic                         valid;
    logic                         ready;
    logic [qbsp_pkg::FIELD_W-1:0] node_index;
    logic [qbsp_pkg::DIST_W-1:0]  distance;
    logic                         unreachable;
    logic                         last;

    modport source
    (
        output valid, node_index, distance, unreachable, last,
        input  ready
    );

    modport sink
    (
        input  valid, node_index, distance, unreachable, last,
        output ready
    );
endinterface

[hw/rtl/qbsp_ctrl.sv]
// Sequencer of the shortest-path core: load, queue pop, edge scan and result walk.
`timescale 1ns / 1ps
module qbsp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_kind,
    input  qbsp_pkg::status_t   status,
    output logic                ready,
    output qbsp_pkg::cmd_t      cmd
);

    qbsp_pkg::state_t                  state_reg;
    qbsp_pkg::state_t                  state_next;
    logic [qbsp_pkg::NODE_W-1:0]       idx_reg;
    logic [qbsp_pkg::NODE_W-1:0]       idx_next;
    logic [qbsp_pkg::NODE_W-1:0]       idx_inc;

    assign idx_inc = (idx_reg == qbsp_pkg::LAST_NODE) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qbsp_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            qbsp_pkg::ST_IDLE:
            begin
                if (item_valid && item_kind == qbsp_pkg::KIND_RUN)
                begin
                    state_next = qbsp_pkg::ST_START;
                end
            end
            qbsp_pkg::ST_START:
            begin
                state_next = qbsp_pkg::ST_POP;
            end
            qbsp_pkg::ST_POP:
            begin
                idx_next   = '0;
                state_next = status.queue_empty ? qbsp_pkg::ST_OUT : qbsp_pkg::ST_SCAN;
            end
            qbsp_pkg::ST_SCAN:
            begin
                idx_next = idx_inc;
                if (idx_reg == qbsp_pkg::LAST_NODE)
                begin
                    state_next = qbsp_pkg::ST_DRAIN;
                end
            end
            qbsp_pkg::ST_DRAIN:
            begin
                state_next = qbsp_pkg::ST_POP;
            end
            qbsp_pkg::ST_OUT:
            begin
                if (status.out_free)
                begin
                    idx_next = idx_inc;
                    if (idx_reg == qbsp_pkg::LAST_NODE)
                    begin
                        state_next = qbsp_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = qbsp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ready     = (state_reg == qbsp_pkg::ST_IDLE);
        cmd.load  = ready && item_valid && item_kind == qbsp_pkg::KIND_LOAD;
        cmd.run   = ready && item_valid && item_kind == qbsp_pkg::KIND_RUN;
        cmd.start = (state_reg == qbsp_pkg::ST_START);
        cmd.pop   = (state_reg == qbsp_pkg::ST_POP) && !status.queue_empty;
        cmd.issue = (state_reg == qbsp_pkg::ST_SCAN);
        cmd.emit  = (state_reg == qbsp_pkg::ST_OUT) && status.out_free;
        cmd.idx   = idx_reg;
    end

endmodule

[hw/rtl/qbsp_dp.sv]
// Datapath: weight memory, distance table, work queue and result register.
`timescale 1ns / 1ps
module qbsp_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  qbsp_pkg::cmd_t                   cmd,
    input  logic [qbsp_pkg::FIELD_W-1:0]     row_node,
    input  logic [qbsp_pkg::FIELD_W-1:0]     col_node,
    input  logic [qbsp_pkg::WEIGHT_W-1:0]    edge_weight,
    input  logic [qbsp_pkg::FIELD_W-1:0]     source_node,
    input  logic                             result_ready,
    output qbsp_pkg::status_t                status,
    output logic                             result_valid,
    output logic [qbsp_pkg::FIELD_W-1:0]     node_index,
    output logic [qbsp_pkg::DIST_W-1:0]      distance,
    output logic                             unreachable,
    output logic                             last
);

    // weight memory with a written bit per entry; unwritten entries read as no edge
    logic [qbsp_pkg::WEIGHT_W-1:0]  wmem [qbsp_pkg::MEM_DEPTH];
    logic [qbsp_pkg::MEM_DEPTH-1:0] wvld_reg;
    logic [qbsp_pkg::WEIGHT_W-1:0]  rdata_reg;
    logic                           rvld_reg;
    logic                           rpend_reg;
    logic [qbsp_pkg::NODE_W-1:0]    ridx_reg;
    logic [qbsp_pkg::ADDR_W-1:0]    waddr;
    logic [qbsp_pkg::ADDR_W-1:0]    raddr;
    logic                           load_ok;

    // distance table, flags and work queue
    logic [qbsp_pkg::DIST_W-1:0]    dist_mem [qbsp_pkg::NODES];
    logic [qbsp_pkg::NODES-1:0]     reached_reg;
    logic [qbsp_pkg::NODES-1:0]     queued_reg;
    logic [qbsp_pkg::NODE_W-1:0]    queue_mem [qbsp_pkg::NODES];
    logic [qbsp_pkg::NODE_W-1:0]    head_reg;
    logic [qbsp_pkg::NODE_W-1:0]    tail_reg;
    logic [qbsp_pkg::CNT_W-1:0]     count_reg;
    logic [qbsp_pkg::FIELD_W-1:0]   src_reg;
    logic [qbsp_pkg::NODE_W-1:0]    src_node;
    logic                           src_ok;
    logic [qbsp_pkg::NODE_W-1:0]    u_reg;
    logic [qbsp_pkg::DIST_W-1:0]    du_reg;

    logic [qbsp_pkg::NODE_W-1:0]    rd_addr;
    logic [qbsp_pkg::DIST_W-1:0]    rd_dist;
    logic                           rd_reached;
    logic                           rd_queued;
    logic [qbsp_pkg::WEIGHT_W-1:0]  w_eff;
    logic                           is_edge;
    logic [qbsp_pkg::DIST_W:0]      sum;
    logic [qbsp_pkg::DIST_W-1:0]    cand;
    logic                           relax;
    logic                           push;

    logic                           out_valid_reg;
    logic [qbsp_pkg::NODE_W-1:0]    out_idx_reg;
    logic [qbsp_pkg::DIST_W-1:0]    out_dist_reg;
    logic                           out_unreach_reg;
    logic                           out_last_reg;

    assign load_ok  = (int'(row_node) < qbsp_pkg::NODES) && (int'(col_node) < qbsp_pkg::NODES);
    assign waddr    = {row_node[qbsp_pkg::NODE_W-1:0], col_node[qbsp_pkg::NODE_W-1:0]};
    assign raddr    = {u_reg, cmd.idx};
    assign src_ok   = int'(src_reg) < qbsp_pkg::NODES;
    assign src_node = src_reg[qbsp_pkg::NODE_W-1:0];

    // one shared read port: queue front on pop, scanned node on relax, else result walk
    always_comb
    begin
        if (cmd.pop)
        begin
            rd_addr = queue_mem[head_reg];
        end
        else if (rpend_reg)
        begin
            rd_addr = ridx_reg;
        end
        else
        begin
            rd_addr = cmd.idx;
        end
    end

    assign rd_dist    = dist_mem[rd_addr];
    assign rd_reached = reached_reg[rd_addr];
    assign rd_queued  = queued_reg[rd_addr];

    // relaxation of the edge fetched last cycle
    assign w_eff   = rvld_reg ? rdata_reg : '0;
    assign is_edge = (w_eff != '0) && (w_eff != qbsp_pkg::NO_EDGE);
    assign sum     = {1'b0, du_reg}
                   + {{(qbsp_pkg::DIST_W + 1 - qbsp_pkg::WEIGHT_W){1'b0}}, w_eff};
    assign cand    = sum[qbsp_pkg::DIST_W] ? qbsp_pkg::DIST_MAX : sum[qbsp_pkg::DIST_W-1:0];
    assign relax   = rpend_reg && is_edge && (!rd_reached || cand < rd_dist);
    assign push    = relax && !rd_queued && (count_reg < qbsp_pkg::CNT_W'(qbsp_pkg::NODES));

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_ok)
        begin
            wmem[waddr] <= edge_weight;
        end
        rdata_reg <= wmem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvld_reg  <= '0;
            rvld_reg  <= 1'b0;
            rpend_reg <= 1'b0;
            ridx_reg  <= '0;
        end
        else
        begin
            if (cmd.load && load_ok)
            begin
                wvld_reg[waddr] <= 1'b1;
            end
            rvld_reg  <= wvld_reg[raddr];
            rpend_reg <= cmd.issue;
            ridx_reg  <= cmd.idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run)
        begin
            src_reg <= source_node;
        end
        if (cmd.pop)
        begin
            u_reg  <= rd_addr;
            du_reg <= rd_dist;
        end
        if (cmd.start && src_ok)
        begin
            dist_mem[src_node] <= '0;
            queue_mem[0]       <= src_node;
        end
        else if (relax)
        begin
            dist_mem[ridx_reg] <= cand;
            if (push)
            begin
                queue_mem[tail_reg] <= ridx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
            queued_reg  <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end
        else if (cmd.start)
        begin
            // clear the previous run and seed the queue with the source
            reached_reg <= '0;
            queued_reg  <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            if (src_ok)
            begin
                reached_reg[src_node] <= 1'b1;
                queued_reg[src_node]  <= 1'b1;
                tail_reg              <= qbsp_pkg::NODE_W'(1);
                count_reg             <= qbsp_pkg::CNT_W'(1);
            end
        end
        else if (cmd.pop)
        begin
            head_reg           <= (head_reg == qbsp_pkg::LAST_NODE) ? '0 : head_reg + 1'b1;
            count_reg          <= count_reg - 1'b1;
            queued_reg[rd_addr] <= 1'b0;
        end
        else if (relax)
        begin
            reached_reg[ridx_reg] <= 1'b1;
            if (push)
            begin
                queued_reg[ridx_reg] <= 1'b1;
                tail_reg  <= (tail_reg == qbsp_pkg::LAST_NODE) ? '0 : tail_reg + 1'b1;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // result register: take a new word whenever the previous one is gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_idx_reg     <= cmd.idx;
            out_dist_reg    <= rd_reached ? rd_dist : qbsp_pkg::UNREACHED_DIST;
            out_unreach_reg <= !rd_reached;
            out_last_reg    <= (cmd.idx == qbsp_pkg::LAST_NODE);
        end
    end

    assign status.queue_empty = (count_reg == '0);
    assign status.out_free    = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign node_index   = qbsp_pkg::FIELD_W'(out_idx_reg);
    assign distance     = out_dist_reg;
    assign unreachable  = out_unreach_reg;
    assign last         = out_last_reg;

endmodule

[hw/rtl/queue_based_shortest_path_core.sv]
// Top level of the queue-based single-source shortest-path core.
`timescale 1ns / 1ps
`include "queue_based_shortest_path_core_defines.svh"
// Use: drive words on the item channel. kind 0 writes one edge weight into the
// 16 x 16 matrix (0 or 9999 mean no edge); kind 1 runs shortest paths from
// source_node. A weight write leaves the block ready, so the next word is
// taken in the following cycle. A run holds item.ready low until its last
// result word is loaded into the result register.
// Run steps: a start state seeds the queue; then for every node popped from
// the work queue a pop state, 16 weight-memory reads (one per cycle, the
// single read port of the weight memory sets this) and a drain state; a
// final pop state sees the queue empty; then 16 result words, one per cycle
// when result.ready stays high. Every run pops at least one node, the source.
// Results come in node order, last set on node 15; unreachable nodes report
// 9999 with unreachable set. A stalled result channel holds the result
// register and pauses the walk; no word is dropped.
// Reset clears the matrix to no-edge at once through per-entry written bits,
// empties the queue and the result register; the block is ready right after.
module queue_based_shortest_path_core
(
    input  logic            clk,
    input  logic            rst_n,
    qbsp_item_if.sink       item,
    qbsp_result_if.source   result
);

    qbsp_pkg::cmd_t    cmd;
    qbsp_pkg::status_t status;
    logic              ctrl_ready;

    assign item.ready = ctrl_ready;

    qbsp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .status     (status),
        .ready      (ctrl_ready),
        .cmd        (cmd)
    );

    qbsp_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .row_node     (item.row_node),
        .col_node     (item.col_node),
        .edge_weight  (item.edge_weight),
        .source_node  (item.source_node),
        .result_ready (result.ready),
        .status       (status),
        .result_valid (result.valid),
        .node_index   (result.node_index),
        .distance     (result.distance),
        .unreachable  (result.unreachable),
        .last         (result.last)
    );

    `QBSP_ASSERT_NEXT(a_run_seeds_queue, item.valid && item.ready && item.kind == qbsp_pkg::KIND_RUN, cmd.start)
    `QBSP_ASSERT_NOW(a_emit_only_busy, cmd.emit, !item.ready)
    `QBSP_ASSERT_NOW(a_unreached_dist, result.valid && result.unreachable, result.distance == qbsp_pkg::UNREACHED_DIST)

endmodule
